>>> rtl/core/b64d_pkg.sv
// shared types, codes and the character map of the base64url decoder
`default_nettype none

package b64d_pkg;

   // end-of-string status codes
   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_CHAR   = 2'd1,
      STATUS_BAD_LENGTH = 2'd2,
      STATUS_BAD_BITS   = 2'd3
   } status_type;

   // input command codes
   typedef enum logic {
      CMD_CHAR = 1'b0,
      CMD_END  = 1'b1
   } command_type;

   // masks for the unused tail bits
   localparam logic [5:0] TAIL2_MASK = 6'h0f;
   localparam logic [5:0] TAIL3_MASK = 6'h03;

   // alphabet offsets
   localparam logic [7:0] LOWER_BASE = 8'd26;
   localparam logic [7:0] DIGIT_BASE = 8'd52;
   localparam logic [5:0] DASH_VALUE = 6'd62;
   localparam logic [5:0] UNDER_VALUE = 6'd63;

   // one mapped character
   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   // work handed from the front to the back: some bytes, then maybe an end word
   typedef struct packed {
      logic [1:0]      n_bytes;
      logic            has_end;
      status_type      status;
      logic [2:0][7:0] bytes;
   } job_type;

   // map one character byte to its 6-bit value
   function automatic sextet_type map_char(input logic [7:0] c);
      sextet_type r;
      logic [7:0] t;
      r = '0;
      t = '0;
      if (c >= 8'h41 && c <= 8'h5a) begin
         t = c - 8'h41;
         r.ok = 1'b1;
         r.value = t[5:0];
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         t = c - 8'h61 + LOWER_BASE;
         r.ok = 1'b1;
         r.value = t[5:0];
      end else if (c >= 8'h30 && c <= 8'h39) begin
         t = c - 8'h30 + DIGIT_BASE;
         r.ok = 1'b1;
         r.value = t[5:0];
      end else if (c == 8'h2d) begin
         r.ok = 1'b1;
         r.value = DASH_VALUE;
      end else if (c == 8'h5f) begin
         r.ok = 1'b1;
         r.value = UNDER_VALUE;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/b64d_front.sv
// front end: accepts characters, tracks the group and turns them into jobs
`default_nettype none

module b64d_front
   import b64d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire logic    command,
   input  wire logic [7:0] char_code,
   output      logic    push,
   output      job_type job
);

   logic [2:0][5:0] held_ff, held_in;
   logic [1:0]      pos_ff, pos_in;
   logic            seen_ff, seen_in;
   status_type      err_ff, err_in;

   sextet_type      sx;
   status_type      end_status;

   // group state, cleared by reset and again by the end command
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         pos_ff  <= '0;
         seen_ff <= 1'b0;
         err_ff  <= STATUS_OK;
      end else begin
         held_ff <= held_in;
         pos_ff  <= pos_in;
         seen_ff <= seen_in;
         err_ff  <= err_in;
      end
   end

   assign sx = map_char(char_code);

   // status of the string at the end command
   always_comb begin
      if (!seen_ff || pos_ff == 2'd1) begin
         end_status = STATUS_BAD_LENGTH;
      end else if (err_ff != STATUS_OK) begin
         end_status = err_ff;
      end else if (pos_ff == 2'd2 && (held_ff[1] & TAIL2_MASK) != 6'd0) begin
         end_status = STATUS_BAD_BITS;
      end else if (pos_ff == 2'd3 && (held_ff[2] & TAIL3_MASK) != 6'd0) begin
         end_status = STATUS_BAD_BITS;
      end else begin
         end_status = STATUS_OK;
      end
   end

   // state update and job build
   always_comb begin
      held_in = held_ff;
      pos_in  = pos_ff;
      seen_in = seen_ff;
      err_in  = err_ff;
      push    = 1'b0;
      job     = '0;
      job.bytes[0] = {held_ff[0], held_ff[1][5:4]};
      job.bytes[1] = {held_ff[1][3:0], held_ff[2][5:2]};
      job.bytes[2] = {held_ff[2][1:0], sx.value};
      if (accept) begin
         if (command == CMD_CHAR) begin
            seen_in = 1'b1;
            pos_in  = pos_ff + 2'd1;
            if (!sx.ok) begin
               if (err_ff == STATUS_OK) begin
                  err_in = STATUS_BAD_CHAR;
               end
            end else if (err_ff == STATUS_OK) begin
               if (pos_ff == 2'd3) begin
                  push = 1'b1;
                  job.n_bytes = 2'd3;
               end else begin
                  held_in[pos_ff] = sx.value;
               end
            end
         end else begin
            push = 1'b1;
            job.has_end = 1'b1;
            job.status  = end_status;
            if (end_status == STATUS_OK && pos_ff >= 2'd2) begin
               job.n_bytes = pos_ff - 2'd1;
            end
            held_in = '0;
            pos_in  = '0;
            seen_in = 1'b0;
            err_in  = STATUS_OK;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/b64d_queue.sv
// short job queue between the front and the back
`default_nettype none

module b64d_queue
   import b64d_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output      job_type head_job,
   output      logic    full,
   output      logic    empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   job_type       slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full     = (cnt_ff == DEPTH_CNT);
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/b64d_back.sv
// back end: walks each job and sends its words through an output register
`default_nettype none

module b64d_back
   import b64d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire job_type head_job,
   input  wire logic    empty,
   output      logic    pop,
   output      logic    rsp_tvalid,
   input  wire logic    rsp_tready,
   output      logic [15:0] rsp_tdata,
   output      logic    rsp_tuser,
   output      logic    rsp_tlast
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvalid_ff, bvalid_in;
   logic       last_ff, last_in;
   status_type status_ff, status_in;

   logic       load;
   logic [2:0] total;
   logic       word_last;

   assign total     = {1'b0, head_job.n_bytes} + {2'b0, head_job.has_end};
   assign word_last = ({1'b0, idx_ff} + 3'd1) == total;
   assign load      = !empty && (!valid_ff || rsp_tready);
   assign pop       = load && word_last;

   // pick the next word of the head job
   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff && !rsp_tready;
      byte_in   = byte_ff;
      bvalid_in = bvalid_ff;
      last_in   = last_ff;
      status_in = status_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = word_last ? 2'd0 : idx_ff + 2'd1;
         if (idx_ff < head_job.n_bytes) begin
            byte_in   = head_job.bytes[idx_ff];
            bvalid_in = 1'b1;
            last_in   = 1'b0;
            status_in = STATUS_OK;
         end else begin
            byte_in   = 8'd0;
            bvalid_in = 1'b0;
            last_in   = 1'b1;
            status_in = head_job.status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output word payload
   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      bvalid_ff <= bvalid_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, status_ff, byte_ff};
   assign rsp_tuser  = bvalid_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

>>> rtl/core/strict_base64url_decoder.sv
// top level of the strict unpadded base64url decoder
`default_nettype none

// Decodes a base64url string sent one character per word, closed by an end
// word (req_tuser high). The front takes one word every cycle while the job
// queue has room; each fourth character yields three byte words, and the end
// word yields up to two tail bytes and then a final word with rsp_tlast high
// and the status. Results leave through one output register at one word per
// cycle with rsp_tready high, so it sustains one character per cycle; a
// result passes the queue before that register. QUEUE_DEPTH sets how many
// jobs can wait while the result side stalls. Bytes sent before an error is
// found are not recalled: drop the string when the final status is non-zero.

module strict_base64url_decoder
   import b64d_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tuser,   // [0] command
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // [7:0] data_byte, [9:8] status
   output      logic        rsp_tuser,   // [0] byte_valid
   output      logic        rsp_tlast    // end_of_decode
);

   logic    accept;
   logic    push;
   job_type push_job;
   job_type head_job;
   logic    full;
   logic    empty;
   logic    pop;

   // a word is taken whenever the queue has room
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   b64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_tuser),
      .char_code (req_tdata),
      .push      (push),
      .job       (push_job)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (full),
      .empty    (empty)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
